// ----- hdl/tpms_pkg.sv -----
// Shared constants and types for the timer prescale and match solver.
package tpms_pkg;

  localparam int unsigned MATCH_MAX    = 65536;
  localparam int unsigned PRESCALE_MAX = 256;

  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned MATCH_W  = $clog2(MATCH_MAX + 1);
  localparam int unsigned PRE_W    = $clog2(PRESCALE_MAX + 1);
  localparam int unsigned SHIFT_W  = $clog2(PRE_W + 1);
  localparam int unsigned SH_W     = MATCH_W + PRE_W;

  // Result of one compare-and-subtract pass of the shared unit.
  typedef struct packed {
    logic                ge;
    logic [PERIOD_W-1:0] diff;
  } sub_res_t;

endpackage

// ----- hdl/tpms_sub.sv -----
// Shared compare-and-subtract unit: remainder minus shifted divisor.
module tpms_sub (
  input  logic [tpms_pkg::PERIOD_W-1:0] rem,
  input  logic [tpms_pkg::MATCH_W-1:0]  divisor,
  input  logic [tpms_pkg::SHIFT_W-1:0]  shift,
  output tpms_pkg::sub_res_t            res
);

  logic [tpms_pkg::SH_W-1:0]     shifted;
  logic [tpms_pkg::PERIOD_W:0]   diff_full;

  assign shifted   = tpms_pkg::SH_W'(divisor) << shift;
  assign diff_full = {1'b0, rem} - (tpms_pkg::PERIOD_W + 1)'(shifted);
  assign res.ge    = ~diff_full[tpms_pkg::PERIOD_W];
  assign res.diff  = diff_full[tpms_pkg::PERIOD_W-1:0];

endmodule

// ----- hdl/timer_prescale_match_solver.sv -----
// Top level: sequencer that scans match values through the shared divide unit.
//
//   channel | signals                                       | direction
//   input   | in_valid, in_ready, period_counts             | into the block
//   output  | out_valid, out_ready, prescale, match_value   | out of the block
//
// A period of at most 65536 skips the scan: the idle state goes straight to the
// finish state, which loads the result. A longer period scans match values
// downward; each candidate takes one range check, 9 restoring divide steps and
// one evaluation in the shared subtract unit, and the scan may also stop on a
// failed range check; it tries at most 65536 candidates.
// One item is in flight at a time; in_ready rises as the result is loaded, and a
// result held by out_ready low stalls the sequencer; rst is synchronous.
module timer_prescale_match_solver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpms_pkg::PERIOD_W-1:0] period_counts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpms_pkg::PRE_W-1:0]    prescale,
  output logic [tpms_pkg::MATCH_W-1:0]  match_value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STEP,
    S_EVAL,
    S_FINISH
  } state_t;

  state_t                        state;
  logic [tpms_pkg::PERIOD_W-1:0] count;
  logic [tpms_pkg::PERIOD_W-1:0] rem;
  logic [tpms_pkg::PERIOD_W-1:0] min_rem;
  logic [tpms_pkg::MATCH_W-1:0]  m;
  logic [tpms_pkg::MATCH_W-1:0]  best_match;
  logic [tpms_pkg::PRE_W-1:0]    q;
  logic [tpms_pkg::PRE_W-1:0]    best_pre;
  logic [tpms_pkg::SHIFT_W-1:0]  bitidx;

  logic [tpms_pkg::PERIOD_W-1:0] sub_rem;
  logic [tpms_pkg::SHIFT_W-1:0]  sub_shift;
  tpms_pkg::sub_res_t            sub_res;

  assign in_ready = (state == S_IDLE);

  // The range check compares the full count against the divisor shifted past
  // the quotient width; divide steps work on the running remainder.
  assign sub_rem   = (state == S_CHECK) ? count : rem;
  assign sub_shift = (state == S_CHECK) ? tpms_pkg::SHIFT_W'(tpms_pkg::PRE_W) : bitidx;

  tpms_sub u_sub (
    .rem     (sub_rem),
    .divisor (m),
    .shift   (sub_shift),
    .res     (sub_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The finish state reloads the output itself when the old item is taken.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            count      <= period_counts;
            min_rem    <= period_counts;
            m          <= tpms_pkg::MATCH_W'(tpms_pkg::MATCH_MAX);
            best_pre   <= tpms_pkg::PRE_W'(1);
            if (period_counts <= tpms_pkg::PERIOD_W'(tpms_pkg::MATCH_MAX)) begin
              best_match <= period_counts[tpms_pkg::MATCH_W-1:0];
              state      <= S_FINISH;
            end else begin
              best_match <= tpms_pkg::MATCH_W'(tpms_pkg::MATCH_MAX);
              state      <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // A quotient beyond the register width is too large; smaller match
          // values only make it larger, so the scan ends here.
          if (sub_res.ge) begin
            state <= S_FINISH;
          end else begin
            rem    <= count;
            q      <= '0;
            bitidx <= tpms_pkg::SHIFT_W'(tpms_pkg::PRE_W - 1);
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          if (sub_res.ge) begin
            rem       <= sub_res.diff;
            q[bitidx] <= 1'b1;
          end
          if (bitidx == '0) begin
            state <= S_EVAL;
          end else begin
            bitidx <= bitidx - tpms_pkg::SHIFT_W'(1);
          end
        end
        S_EVAL: begin
          if (q > tpms_pkg::PRE_W'(tpms_pkg::PRESCALE_MAX)) begin
            state <= S_FINISH;
          end else if (rem == '0) begin
            best_pre   <= q;
            best_match <= m;
            state      <= S_FINISH;
          end else begin
            if (rem < min_rem) begin
              min_rem    <= rem;
              best_pre   <= q;
              best_match <= m;
            end
            if (m == tpms_pkg::MATCH_W'(1)) begin
              state <= S_FINISH;
            end else begin
              m     <= m - tpms_pkg::MATCH_W'(1);
              state <= S_CHECK;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            prescale    <= best_pre;
            match_value <= best_match;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (rem < tpms_pkg::PERIOD_W'(m)))
    else $error("remainder not below divisor after divide steps");

  a_match_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (m != '0))
    else $error("scan reached a zero match value");

  a_prescale_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prescale != '0) &&
                  (prescale <= tpms_pkg::PRE_W'(tpms_pkg::PRESCALE_MAX)))
    else $error("prescale out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted item did not start the sequencer");
`endif

endmodule
